FILE: rtl/luenberger_velocity_observer_defines.svh
// Assertion macros for the velocity observer checker
`ifndef LUENBERGER_VELOCITY_OBSERVER_DEFINES_SVH
`define LUENBERGER_VELOCITY_OBSERVER_DEFINES_SVH

// implication checked on every clock edge outside reset
`define LVO_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define LVO_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lvo_pkg.sv
package lvo_pkg;

  localparam int SIGNAL_FRAC_BITS = 16;
  localparam int COEF_FRAC_BITS   = 24;
  // rounded products and their sums with an estimate fit here
  localparam int ACC_W            = 67 - COEF_FRAC_BITS;

  localparam logic [2:0] CFG_TIME_STEP  = 3'd0;
  localparam logic [2:0] CFG_POS_GAIN   = 3'd1;
  localparam logic [2:0] CFG_VEL_GAIN   = 3'd2;
  localparam logic [2:0] CFG_DAMPING    = 3'd3;
  localparam logic [2:0] CFG_DRIVE      = 3'd4;
  localparam logic [2:0] CFG_INIT_POS   = 3'd5;
  localparam logic [2:0] CFG_INIT_VEL   = 3'd6;

  typedef struct packed {
    logic signed [31:0] drive_torque;
    logic signed [31:0] measured_position;
    logic               restart;
  } lvo_in_t;

  typedef struct packed {
    logic signed [31:0] position_estimate;
    logic signed [31:0] velocity_estimate;
    logic               saturated;
  } lvo_out_t;

  // serial multiplier control/status
  typedef struct packed {
    logic start;
  } lvo_mul_ctl_t;

  typedef struct packed {
    logic done;
  } lvo_mul_sts_t;

endpackage

FILE: rtl/lvo_serial_mul.sv
// Bit-serial signed multiplier: 33-bit signed multiplicand by 32-bit signed
// multiplier, one multiplier bit per cycle, exact 65-bit product.
module lvo_serial_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lvo_pkg::lvo_mul_ctl_t      ctl,
  input  logic signed [32:0]         mcand,
  input  logic signed [31:0]         mplier,
  output lvo_pkg::lvo_mul_sts_t      sts,
  output logic signed [64:0]         product
);

  logic               busy_r, busy_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic signed [32:0] mcand_r;
  logic [31:0]        mplier_r;
  logic signed [64:0] acc_r, acc_nxt;
  logic               done_r, done_nxt;
  logic signed [64:0] addend;

  always_comb begin
    addend = {{32{mcand_r[32]}}, mcand_r} <<< cnt_r;
    acc_nxt = acc_r;
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      acc_nxt = '0;
      busy_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        if (cnt_r == 5'd31) begin
          acc_nxt = acc_r - addend;
        end else begin
          acc_nxt = acc_r + addend;
        end
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    if (ctl.start) begin
      mcand_r  <= mcand;
      mplier_r <= mplier;
    end else if (busy_r) begin
      mplier_r <= {1'b0, mplier_r[31:1]};
    end
  end

  assign sts.done = done_r;
  assign product  = acc_r;

endmodule

FILE: rtl/luenberger_velocity_observer.sv
// Luenberger velocity observer, two states, forward Euler, fixed point.
// Channels: in_valid/in_stall/in_data carry drive torque, measured position
// and a restart flag; out_valid/out_stall/out_data carry the new position
// and velocity estimates and a saturation flag. A transaction completes
// when valid is high and stall is low. cfg_valid/cfg_ready/cfg_index/
// cfg_data write the seven coefficient registers; index 7 is ignored.
// Each normal item takes five products, each one started, worked through
// bit by bit and marked done, then a summing state and an output state
// that loads the result register; a restart result is valid the
// cycle after acceptance. One item is in work at a time, set by the single
// shared bit-serial multiplier: no new item is taken until the state is idle.
// The result sits in an output register; while it waits for a stalled
// receiver the input is stalled too, and no new item is taken.
// Reset (synchronous, rst_n low) restores the default coefficients and
// zeroes both estimates; no transaction is pending after reset.
module luenberger_velocity_observer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lvo_pkg::lvo_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lvo_pkg::lvo_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  localparam int CFB = lvo_pkg::COEF_FRAC_BITS;
  localparam int AW  = lvo_pkg::ACC_W;

  localparam logic [63:0] RST_DT  = ((64'd1 << CFB) + 64'd500) / 64'd1000;
  localparam logic [63:0] RST_G0  = ((64'd415 << CFB) + 64'd500) / 64'd1000;
  localparam logic [63:0] RST_G1  = ((64'd41925 << CFB) + 64'd500) / 64'd1000;
  localparam logic [63:0] RST_A   = 64'd0 - ((64'd5 << CFB) + 64'd500) / 64'd1000;
  localparam logic [63:0] RST_D   = 64'd1 << (CFB - 1);

  logic [30:0] dt_r;
  logic [31:0] g0_r, g1_r, a_r, d_r, ip_r, iv_r;
  logic signed [31:0] pos_r, vel_r;
  logic signed [32:0] innov_r;
  logic signed [31:0] u_r;
  logic [2:0]  st_r;
  logic [2:0]  term_r;
  logic signed [AW-1:0] pacc_r, vacc_r;
  lvo_pkg::lvo_out_t res_r;

  lvo_pkg::lvo_mul_ctl_t mctl;
  lvo_pkg::lvo_mul_sts_t msts;
  logic signed [32:0] mcand;
  logic signed [31:0] mplier;
  logic signed [64:0] prod;
  logic signed [64:0] rnd;
  logic signed [AW-1:0] rnd_n;
  logic signed [AW-1:0] np, nv;
  logic signed [31:0] np_c, nv_c;
  logic               in_fire, out_fire;
  logic               sat_p, sat_v;
  logic               start_nxt, res_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (st_r != ST_IDLE) || (out_valid && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;

  assign res_load  = ((st_r == ST_IDLE) && in_fire && in_data.restart) || (st_r == ST_OUT);
  assign start_nxt = ((st_r == ST_IDLE) && in_fire && !in_data.restart)
                  || ((st_r == ST_MUL) && msts.done && (term_r != 3'd4));

  always_comb begin
    case (term_r)
      3'd0: begin mcand = {{2{vel_r[31]}}, vel_r[30:0]}; mplier = {1'b0, dt_r}; end
      3'd1: begin mcand = innov_r; mplier = g0_r; end
      3'd2: begin mcand = {vel_r[31], vel_r}; mplier = a_r; end
      3'd3: begin mcand = {u_r[31], u_r}; mplier = d_r; end
      default: begin mcand = innov_r; mplier = g1_r; end
    endcase
  end

  lvo_serial_mul u_mul (
    .clk(clk), .rst_n(rst_n), .ctl(mctl), .mcand(mcand), .mplier(mplier),
    .sts(msts), .product(prod)
  );

  // round half up: add half lsb then arithmetic shift
  assign rnd   = (prod + (65'sd1 <<< (CFB - 1))) >>> CFB;
  assign rnd_n = rnd[AW-1:0];

  assign np = pacc_r;
  assign nv = vacc_r;
  assign sat_p = (np[AW-1:31] != {(AW - 31){np[31]}});
  assign sat_v = (nv[AW-1:31] != {(AW - 31){nv[31]}});
  assign np_c  = sat_p ? (np[AW-1] ? 32'sh80000000 : 32'sh7FFFFFFF) : np[31:0];
  assign nv_c  = sat_v ? (nv[AW-1] ? 32'sh80000000 : 32'sh7FFFFFFF) : nv[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r  <= RST_DT[30:0];
      g0_r  <= RST_G0[31:0];
      g1_r  <= RST_G1[31:0];
      a_r   <= RST_A[31:0];
      d_r   <= RST_D[31:0];
      ip_r  <= '0;
      iv_r  <= '0;
      pos_r <= '0;
      vel_r <= '0;
      st_r  <= ST_IDLE;
      term_r <= '0;
      out_valid <= 1'b0;
      mctl.start <= 1'b0;
    end else begin
      mctl.start <= start_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lvo_pkg::CFG_TIME_STEP: dt_r <= cfg_data[30:0];
          lvo_pkg::CFG_POS_GAIN:  g0_r <= cfg_data;
          lvo_pkg::CFG_VEL_GAIN:  g1_r <= cfg_data;
          lvo_pkg::CFG_DAMPING:   a_r  <= cfg_data;
          lvo_pkg::CFG_DRIVE:     d_r  <= cfg_data;
          lvo_pkg::CFG_INIT_POS:  ip_r <= cfg_data;
          lvo_pkg::CFG_INIT_VEL:  iv_r <= cfg_data;
          default: ;
        endcase
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_data.restart) begin
              pos_r <= ip_r;
              vel_r <= iv_r;
              res_r <= '{ip_r, iv_r, 1'b0};
            end else begin
              innov_r <= {in_data.measured_position[31], in_data.measured_position}
                         - {pos_r[31], pos_r};
              u_r     <= in_data.drive_torque;
              pacc_r  <= {{(AW - 32){pos_r[31]}}, pos_r};
              vacc_r  <= {{(AW - 32){vel_r[31]}}, vel_r};
              term_r  <= '0;
              st_r    <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (msts.done) begin
            if (term_r < 3'd2) begin
              pacc_r <= pacc_r + rnd_n;
            end else begin
              vacc_r <= vacc_r + rnd_n;
            end
            if (term_r == 3'd4) begin
              st_r <= ST_SUM;
            end else begin
              term_r <= term_r + 3'd1;
            end
          end
        end
        ST_SUM: begin
          if (!out_valid || out_fire) begin
            st_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          pos_r <= np_c;
          vel_r <= nv_c;
          res_r.position_estimate <= np_c;
          res_r.velocity_estimate <= nv_c;
          res_r.saturated <= sat_p || sat_v;
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_data = res_r;

endmodule

FILE: rtl/lvo_checker.sv
`include "luenberger_velocity_observer_defines.svh"

module lvo_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input lvo_pkg::lvo_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input lvo_pkg::lvo_out_t out_data
);

  `LVO_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
  `LVO_ASSERT_NXT(a_restart_quick, clk, rst_n, in_valid && !in_stall && in_data.restart, out_valid, "restart result missing")
  `LVO_ASSERT_IMP(a_busy_stall, clk, rst_n, out_valid && out_stall, in_stall, "input taken while result blocked")
  `LVO_ASSERT_NXT(a_restart_sat, clk, rst_n, in_valid && !in_stall && in_data.restart, !out_data.saturated, "restart flagged saturation")

endmodule

bind luenberger_velocity_observer lvo_checker u_lvo_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // observer predictor and queue of expected estimates
  class observer_scoreboard;
    logic [30:0] dt;
    logic signed [31:0] g_pos, g_vel, damp, drive, init_pos, init_vel;
    logic signed [31:0] pos, vel;
    lvo_pkg::lvo_out_t est_q[$];
    int errors;
    int checked;
    int restarts;
    int clips;

    function void reset_state();
      dt = 31'd16777;
      g_pos = 32'sd6962545;
      g_vel = 32'sd703384781;
      damp = -32'sd83886;
      drive = 32'sd8388608;
      init_pos = 0;
      init_vel = 0;
      pos = 0;
      vel = 0;
      est_q.delete();
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        lvo_pkg::CFG_TIME_STEP: dt = v[30:0];
        lvo_pkg::CFG_POS_GAIN:  g_pos = v;
        lvo_pkg::CFG_VEL_GAIN:  g_vel = v;
        lvo_pkg::CFG_DAMPING:   damp = v;
        lvo_pkg::CFG_DRIVE:     drive = v;
        lvo_pkg::CFG_INIT_POS:  init_pos = v;
        lvo_pkg::CFG_INIT_VEL:  init_vel = v;
        default: ;
      endcase
    endfunction

    // shift right by 24, rounding half up
    function logic signed [71:0] rnd(logic signed [71:0] p);
      rnd = (p >>> 24) + $signed({1'b0, p[23]});
    endfunction

    function logic signed [31:0] clip(logic signed [71:0] v, inout logic f);
      if (v > 72'sh7fffffff) begin
        f = 1'b1;
        clip = 32'sh7fffffff;
      end else if (v < -72'sh80000000) begin
        f = 1'b1;
        clip = 32'sh80000000;
      end else begin
        clip = v[31:0];
      end
    endfunction

    function void note_input(lvo_pkg::lvo_in_t it);
      logic signed [71:0] innov, np, nv, p, v;
      lvo_pkg::lvo_out_t e;
      logic f;
      f = 1'b0;
      if (it.restart) begin
        pos = init_pos;
        vel = init_vel;
        restarts++;
      end else begin
        p = pos;
        v = vel;
        innov = 72'(it.measured_position) - p;
        np = p + rnd(72'($signed({1'b0, dt})) * v) + rnd(72'(g_pos) * innov);
        nv = v + rnd(72'(damp) * v) + rnd(72'(drive) * 72'(it.drive_torque))
             + rnd(72'(g_vel) * innov);
        pos = clip(np, f);
        vel = clip(nv, f);
        if (f) clips++;
      end
      e.position_estimate = pos;
      e.velocity_estimate = vel;
      e.saturated = f;
      est_q = {est_q, e};
    endfunction

    function void check_result(lvo_pkg::lvo_out_t r);
      lvo_pkg::lvo_out_t e;
      if (est_q.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h", $time, r);
        errors++;
        return;
      end
      e = est_q.pop_front();
      checked++;
      if (r.position_estimate !== e.position_estimate) begin
        $display("%0t: position expected %0d actual %0d", $time,
                 e.position_estimate, r.position_estimate);
        errors++;
      end
      if (r.velocity_estimate !== e.velocity_estimate) begin
        $display("%0t: velocity expected %0d actual %0d", $time,
                 e.velocity_estimate, r.velocity_estimate);
        errors++;
      end
      if (r.saturated !== e.saturated) begin
        $display("%0t: saturated expected %0b actual %0b", $time,
                 e.saturated, r.saturated);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lvo_pkg::lvo_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lvo_pkg::lvo_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  observer_scoreboard sb = new();
  bit no_idle = 1'b0;
  bit hold_off = 1'b0;
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  luenberger_velocity_observer i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d estimates outstanding", $time,
                 sb.est_q.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls, none in no-idle mode, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (no_idle) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 9);
  end

  // valid stays up after acceptance until the next item or drain() replaces it
  task automatic send_item(lvo_pkg::lvo_in_t it);
    if (!no_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while (!no_idle && $urandom_range(99) < 9) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.est_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic lvo_pkg::lvo_in_t rand_item(int restart_pct, int span);
    lvo_pkg::lvo_in_t it;
    it.restart = ($urandom_range(99) < restart_pct);
    it.drive_torque = (span == 0) ? $urandom() : $signed($urandom_range(2 * span)) - span;
    it.measured_position = (span == 0) ? $urandom() :
                           $signed($urandom_range(2 * span)) - span;
    return it;
  endfunction

  task automatic run_random(int n, int restart_pct, int span);
    repeat (n) begin
      if ($urandom_range(9) == 0) send_item(rand_item(restart_pct, 0));
      else send_item(rand_item(restart_pct, span));
    end
  endtask

  task automatic write_all(logic [31:0] v[7]);
    for (int k = 0; k < 7; k++) write_cfg(3'(k), v[k]);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    lvo_pkg::lvo_in_t it;
    logic [31:0] regs[7];
    sb.reset_state();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: defaults, field extremes, restart, saturation
    it = '{drive_torque: 32'sh7fffffff, measured_position: 32'sh7fffffff, restart: 1'b0};
    send_item(it);
    it = '{drive_torque: 32'sh80000000, measured_position: 32'sh80000000, restart: 1'b0};
    send_item(it);
    send_item(it);
    it = '{drive_torque: 32'sh0, measured_position: 32'sh0, restart: 1'b1};
    send_item(it);
    it = '{drive_torque: 32'sh0, measured_position: 32'sh0, restart: 1'b0};
    send_item(it);
    it = '{drive_torque: 32'sh10000, measured_position: 32'sh10000, restart: 1'b0};
    repeat (4) send_item(it);
    it = '{drive_torque: -32'sh1, measured_position: 32'sh7fffffff, restart: 1'b1};
    send_item(it);
    drain();

    // extreme coefficients and initial estimates
    regs = '{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
             32'h80000000, 32'h7fffffff, 32'h80000000};
    write_all(regs);
    it = '{drive_torque: 32'sh0, measured_position: 32'sh0, restart: 1'b1};
    send_item(it);
    it = '{drive_torque: 32'sh7fffffff, measured_position: 32'sh80000000, restart: 1'b0};
    send_item(it);
    send_item(it);
    it = '{drive_torque: 32'sh80000000, measured_position: 32'sh7fffffff, restart: 1'b0};
    send_item(it);
    drain();
    regs = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    write_all(regs);
    it = '{drive_torque: 32'sh12345678, measured_position: 32'sh9abcdef0, restart: 1'b0};
    send_item(it);
    it.restart = 1'b1;
    send_item(it);
    drain();
    write_cfg(3'd7, 32'hffffffff);

    // random: realistic gains, then random coefficients
    regs = '{32'd16777, 32'd6962545, 32'd703384781, -32'sd83886, 32'd8388608,
             32'h0, 32'h0};
    write_all(regs);
    run_random(200, 3, 200000);

    // receiver holds off while the sender keeps going
    hold_off = 1'b1;
    fork
      begin
        repeat (1500) @(negedge clk);
        hold_off = 1'b0;
      end
      run_random(6, 3, 200000);
    join
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 7; k++)
        regs[k] = (k < 5 && ph < 2) ? $urandom_range(32'h02000000) -
                  ((k == 0) ? 0 : 32'h01000000) : $urandom();
      regs[0] = {1'b0, regs[0][30:0]};
      write_all(regs);
      send_item('{drive_torque: 32'sh0, measured_position: 32'sh0, restart: 1'b1});
      no_idle = (ph == 1);
      run_random(140, 5, (ph < 2) ? 100000 : 0);
      no_idle = 1'b0;
      drain();
    end

    $display("Checked %0d estimates (%0d restarts, %0d saturating steps)",
             sb.checked, sb.restarts, sb.clips);
    $display("across default, extreme, zero and random coefficient sets.");
    if (sb.errors == 0 && sb.est_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
